[src/ght_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types and constants of the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int KIND_COUNT = 4;
    localparam int ID_COUNT   = 1024;
    localparam int TABLE_SIZE = KIND_COUNT * ID_COUNT;
    localparam int IX_W       = $clog2(TABLE_SIZE);

    localparam int KIND_W = 2;
    localparam int ID_W   = 10;
    localparam int WORD_W = 64;

    // opcodes
    localparam logic [3:0] OP_RESTART     = 4'd0;
    localparam logic [3:0] OP_DISCOVER    = 4'd1;
    localparam logic [3:0] OP_CREATED     = 4'd2;
    localparam logic [3:0] OP_RESOLVE     = 4'd3;
    localparam logic [3:0] OP_MARK_DEAD   = 4'd4;
    localparam logic [3:0] OP_RETIRE      = 4'd5;
    localparam logic [3:0] OP_IS_DEAD     = 4'd6;
    localparam logic [3:0] OP_IS_ALIVE    = 4'd7;
    localparam logic [3:0] OP_IS_AWAITING = 4'd8;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // flag bit positions
    localparam int FL_ALIVE    = 0;
    localparam int FL_DEAD     = 1;
    localparam int FL_NOTIFIED = 2;

    localparam int IN_TDATA_W  = 216;
    localparam int OUT_TDATA_W = 144;

    // last field in the lowest bits
    typedef struct packed {
        logic              awaiting_creation;
        logic [WORD_W-1:0] key_epoch;
        logic [WORD_W-1:0] key_generation;
        logic [WORD_W-1:0] token;
        logic [ID_W-1:0]   entity_id;
        logic [KIND_W-1:0] kind;
        logic [3:0]        opcode;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              answer;
        logic [WORD_W-1:0] out_epoch;
        logic [WORD_W-1:0] out_generation;
        logic [ID_W-1:0]   out_id;
        logic [KIND_W-1:0] out_kind;
    } res_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] token;
        logic [WORD_W-1:0] generation;
        logic [WORD_W-1:0] epoch;
        logic [2:0]        flags;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        entry_t wr_data;
        logic   restart;
        res_t   res;
    } exec_t;

endpackage

[src/ght_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ght_exec
// Modify step of one request: new entry contents and the result item.
// ----------------------------------------------------------------------------
module ght_exec
    import ght_pkg::*;
(
    input  req_t              req,
    input  entry_t            ent,
    input  logic [WORD_W-1:0] cur_epoch,
    output exec_t             exe
);

    logic              in_range;
    logic              key_hit;
    logic              need_new;
    logic              have;
    logic [WORD_W-1:0] base_gen;
    entry_t            upd;
    res_t              res;
    logic              wr_en;

    always_comb
    begin
        in_range = (32'(req.kind) < KIND_COUNT) && (32'(req.entity_id) < ID_COUNT);
        key_hit  = ent.valid && (ent.generation == req.key_generation)
                   && (ent.epoch == req.key_epoch);
        need_new = !ent.valid || !ent.flags[FL_ALIVE] || (ent.token != req.token);
        base_gen = ent.valid ? ent.generation : '0;
        upd      = ent;
        res      = '0;
        have     = 1'b0;
        wr_en    = 1'b0;

        unique case (req.opcode)
            OP_RESTART:
            begin
            end
            OP_DISCOVER, OP_CREATED:
            begin
                if (!in_range)
                    res.status = ST_RANGE;
                else if (req.token != '0 && req.kind != '0)
                begin
                    if (need_new && base_gen == '1)
                        res.status = ST_EXHAUSTED;
                    else
                    begin
                        have  = 1'b1;
                        wr_en = 1'b1;
                        if (need_new)
                        begin
                            upd.valid      = 1'b1;
                            upd.token      = req.token;
                            upd.generation = base_gen + 64'd1;
                            upd.epoch      = cur_epoch;
                            upd.flags      = '0;
                            upd.flags[FL_ALIVE]    = 1'b1;
                            upd.flags[FL_NOTIFIED] = !(req.opcode == OP_DISCOVER
                                                       && req.awaiting_creation);
                        end
                        if (req.opcode == OP_CREATED)
                            upd.flags[FL_NOTIFIED] = 1'b1;
                    end
                end
            end
            OP_RESOLVE:
            begin
                if (!in_range)
                    res.status = ST_RANGE;
                else
                    have = ent.valid && (ent.token == req.token);
            end
            OP_MARK_DEAD:
            begin
                if (!in_range)
                    res.status = ST_RANGE;
                else if (key_hit)
                begin
                    wr_en = 1'b1;
                    upd.flags[FL_DEAD] = 1'b1;
                end
            end
            OP_RETIRE:
            begin
                if (!in_range)
                    res.status = ST_RANGE;
                else if (key_hit)
                begin
                    wr_en = 1'b1;
                    upd.flags[FL_ALIVE] = 1'b0;
                end
            end
            OP_IS_DEAD:
            begin
                if (!in_range)
                    res.status = ST_RANGE;
                else
                    res.answer = key_hit && ent.flags[FL_DEAD];
            end
            OP_IS_ALIVE:
            begin
                if (!in_range)
                    res.status = ST_RANGE;
                else
                    res.answer = key_hit && ent.flags[FL_ALIVE];
            end
            OP_IS_AWAITING:
            begin
                if (!in_range)
                    res.status = ST_RANGE;
                else
                    res.answer = key_hit && !ent.flags[FL_NOTIFIED];
            end
            default:
            begin
            end
        endcase

        if (have)
        begin
            res.out_kind       = req.kind;
            res.out_id         = req.entity_id;
            res.out_generation = upd.generation;
            res.out_epoch      = upd.epoch;
        end

        exe.wr_en   = wr_en;
        exe.wr_data = upd;
        exe.restart = (req.opcode == OP_RESTART);
        exe.res     = res;
    end

endmodule

[src/generational_handle_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_table
// Directly indexed table of generational handles held in one entry memory.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one result per request leaves on the
// m_axis channel. Every request is a read-modify-write of one table entry
// at kind * ID_COUNT + entity_id: the entry is read into a register when the
// request is accepted, and when the execute step fires the updated entry is
// written back and the result lands in the output register. The block takes
// no new request until the current one has been written back and answered.
// If the output register still holds a result the receiver has not taken,
// the request waits in the execute step and s_axis_tready stays low.
// Restart answers at once, then sweeps the memory clearing every valid bit,
// one entry per cycle, with s_axis_tready low until the sweep is done.
// After reset the same clearing pass runs before the first request is taken;
// the epoch starts at zero and no result is pending.
// ----------------------------------------------------------------------------
module generational_handle_table
    import ght_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // opcode, kind, entity_id, token, key_generation, key_epoch,
    // awaiting_creation, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // out_kind, out_id, out_generation, out_epoch, answer, status, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    localparam int REQ_W = $bits(req_t);
    localparam int RES_W = $bits(res_t);

    logic [1:0]        state_reg, state_next;
    logic [IX_W-1:0]   clr_reg, clr_next;
    logic [WORD_W-1:0] epoch_reg, epoch_next;
    logic              ovalid_reg, ovalid_next;
    res_t              ores_reg;
    req_t              req_reg;
    logic [IX_W-1:0]   ix_reg;
    entry_t            rd_reg;

    entry_t            mem [TABLE_SIZE];

    req_t              req_in;
    logic [IX_W-1:0]   ix_in;
    logic              accept;
    logic              out_free;
    logic              fire;
    exec_t             exe;
    logic              mem_we;
    logic [IX_W-1:0]   mem_wa;
    entry_t            mem_wd;

    assign req_in   = req_t'(s_axis_tdata[REQ_W-1:0]);
    assign ix_in    = IX_W'(IX_W'(req_in.kind) * IX_W'(ID_COUNT)) + IX_W'(req_in.entity_id);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;
    assign fire     = (state_reg == S_EXEC) && out_free;

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RES_W){1'b0}}, ores_reg};

    ght_exec u_exec (
        .req       (req_reg),
        .ent       (rd_reg),
        .cur_epoch (epoch_reg),
        .exe       (exe)
    );

    // single write port: clearing sweep or request write-back
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = '0;
        end
        else
        begin
            mem_we = fire && exe.wr_en;
            mem_wa = ix_reg;
            mem_wd = exe.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (accept)
            rd_reg <= mem[ix_in];
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        epoch_next  = epoch_reg;
        ovalid_next = ovalid_reg;

        if (m_axis_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + IX_W'(1);
                if (32'(clr_reg) == TABLE_SIZE - 1)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (exe.restart)
                    begin
                        epoch_next = req_reg.key_epoch;
                        state_next = S_CLEAR;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            epoch_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            epoch_reg  <= epoch_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_in;
            ix_reg  <= ix_in;
        end
        if (fire)
            ores_reg <= exe.res;
    end

endmodule
